// ===== src/mlt_pkg.sv =====
// Shared types and constants for the makefile line tokenizer.
// Used by the top level; no dependencies.
package mlt_pkg;

  // Length counter width and its saturation value
  localparam int unsigned LenWidth = 16;
  localparam logic [LenWidth-1:0] LenMax = {LenWidth{1'b1}};

  // Byte codes that steer the scan
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChColon   = 8'h3A;
  localparam logic [7:0] ChEquals  = 8'h3D;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChDollar  = 8'h24;
  localparam logic [7:0] ChParen   = 8'h28;

  // Token classes
  localparam logic [2:0] ClsIdent      = 3'd0;
  localparam logic [2:0] ClsColon      = 3'd1;
  localparam logic [2:0] ClsEquals     = 3'd2;
  localparam logic [2:0] ClsPlusEquals = 3'd3;
  localparam logic [2:0] ClsTab        = 3'd4;
  localparam logic [2:0] ClsVariable   = 3'd5;
  localparam logic [2:0] ClsNewline    = 3'd6;
  localparam logic [2:0] ClsEof        = 3'd7;

  // Record kinds
  localparam logic KindEcho   = 1'b0;
  localparam logic KindRecord = 1'b1;

  // Most results one item can cause
  localparam int unsigned MaxResults = 3;

  // One result item
  typedef struct packed {
    logic        record_kind;
    logic [7:0]  out_character;
    logic [2:0]  token_class;
    logic [15:0] token_length;
    logic        last_of_run;
  } rec_t;

endpackage

// ===== src/mlt_in_if.sv =====
// Input channel of the makefile line tokenizer: one text byte per item.
// Stand-alone valid/ready interface; no dependencies.
interface mlt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_input;

  modport source (output valid, output character, output end_of_input, input ready);
  modport sink   (input valid, input character, input end_of_input, output ready);
endinterface

// ===== src/mlt_out_if.sv =====
// Result channel of the makefile line tokenizer: echoes and token records.
// Stand-alone valid/ready interface; no dependencies.
interface mlt_out_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [7:0]  out_character;
  logic [2:0]  token_class;
  logic [15:0] token_length;
  logic        last_of_run;

  modport source (output valid, output record_kind, output out_character,
                  output token_class, output token_length, output last_of_run,
                  input ready);
  modport sink   (input valid, input record_kind, input out_character,
                  input token_class, input token_length, input last_of_run,
                  output ready);
endinterface

// ===== src/makefile_line_tokenizer.sv =====
// Top level of the makefile line tokenizer: scan state and result queue.
// Depends on mlt_pkg, mlt_in_if and mlt_out_if.
//
// Usage:
//   in_chan  (sink)   one makefile byte per item, or an end marker with
//                     end_of_input set (character then ignored).
//   out_chan (source) echoed token bytes (record_kind 0) and completed
//                     records (record_kind 1) with class and length;
//                     last_of_run marks the final result of one item.
// An item is taken when valid and ready are both high. Its results (zero
// to three) are computed in the same cycle and held in a three-entry
// result queue; the first appears on out_chan in the cycle after
// acceptance. Throughput is one item per cycle while out_chan.ready is
// high and each item gives at most one result; an item that gives two or
// three results (token end with newline or end marker) holds in_chan.ready
// low until the queue has drained to its last entry, which is the queue
// depth that sets the rate. When out_chan.ready is low the head result
// holds and input stops once the queue is not draining. Synchronous reset
// (rst_n low) empties the queue and returns the scan state to line start;
// the end marker does the same to the scan state after its results.
module makefile_line_tokenizer (
  input logic          clk,
  input logic          rst_n,
  mlt_in_if.sink       in_chan,
  mlt_out_if.source    out_chan
);

  // Scan state
  logic                            at_line_start_r, at_line_start_nxt;
  logic                            line_has_content_r, line_has_content_nxt;
  logic                            in_comment_r, in_comment_nxt;
  logic                            whole_line_mode_r, whole_line_mode_nxt;
  logic [mlt_pkg::LenWidth-1:0]    cur_len_r, cur_len_nxt;
  logic [7:0]                      first_byte_r, first_byte_nxt;
  logic [7:0]                      second_byte_r, second_byte_nxt;

  // Result queue, head at entry 0
  mlt_pkg::rec_t                   rec_r [mlt_pkg::MaxResults];
  logic [1:0]                      cnt_r, cnt_nxt;

  // New results of the current item
  mlt_pkg::rec_t                   gen [mlt_pkg::MaxResults];
  logic [1:0]                      gen_cnt;

  logic                            in_fire, out_fire;
  logic                            pend_tok;
  mlt_pkg::rec_t                   tok_rec;
  logic [2:0]                      tok_cls;
  logic [15:0]                     tok_len;
  logic [7:0]                      ch;

  assign ch       = in_chan.character;
  assign out_fire = out_chan.valid && out_chan.ready;
  // Accept when the queue is empty or giving up its last entry
  assign in_chan.ready = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_chan.ready);
  assign in_fire  = in_chan.valid && in_chan.ready;

  // Classify the pending token
  always_comb begin
    tok_cls = mlt_pkg::ClsIdent;
    if (cur_len_r == mlt_pkg::LenWidth'(1) && first_byte_r == mlt_pkg::ChColon) begin
      tok_cls = mlt_pkg::ClsColon;
    end else if (cur_len_r == mlt_pkg::LenWidth'(1) && first_byte_r == mlt_pkg::ChEquals) begin
      tok_cls = mlt_pkg::ClsEquals;
    end else if (cur_len_r == mlt_pkg::LenWidth'(1) && first_byte_r == mlt_pkg::ChTab) begin
      tok_cls = mlt_pkg::ClsTab;
    end else if (cur_len_r == mlt_pkg::LenWidth'(2) && first_byte_r == mlt_pkg::ChPlus &&
                 second_byte_r == mlt_pkg::ChEquals) begin
      tok_cls = mlt_pkg::ClsPlusEquals;
    end else if (cur_len_r >= mlt_pkg::LenWidth'(2) && first_byte_r == mlt_pkg::ChDollar &&
                 second_byte_r == mlt_pkg::ChParen) begin
      tok_cls = mlt_pkg::ClsVariable;
    end
  end

  // Clamp the length to the 16-bit result field
  always_comb begin
    if (32'(cur_len_r) > 32'hFFFF) begin
      tok_len = 16'hFFFF;
    end else begin
      tok_len = 16'(cur_len_r);
    end
  end

  assign pend_tok = (cur_len_r != '0);
  assign tok_rec  = '{record_kind: mlt_pkg::KindRecord, out_character: 8'd0,
                      token_class: tok_cls, token_length: tok_len, last_of_run: 1'b0};

  // Build the results of this item and the next scan state
  always_comb begin
    mlt_pkg::rec_t blank;
    logic          flush;
    blank = '{record_kind: mlt_pkg::KindRecord, out_character: 8'd0,
              token_class: mlt_pkg::ClsIdent, token_length: 16'd0, last_of_run: 1'b0};
    for (int i = 0; i < mlt_pkg::MaxResults; i++) begin
      gen[i] = blank;
    end
    gen_cnt              = 2'd0;
    flush                = 1'b0;
    at_line_start_nxt    = at_line_start_r;
    line_has_content_nxt = line_has_content_r;
    in_comment_nxt       = in_comment_r;
    whole_line_mode_nxt  = whole_line_mode_r;
    cur_len_nxt          = cur_len_r;
    first_byte_nxt       = first_byte_r;
    second_byte_nxt      = second_byte_r;

    if (in_chan.end_of_input) begin
      // Close the pending token and line, then mark end of file
      if (pend_tok) begin
        gen[gen_cnt] = tok_rec;
        gen_cnt      = gen_cnt + 2'd1;
      end
      if (line_has_content_r) begin
        gen[gen_cnt].token_class = mlt_pkg::ClsNewline;
        gen_cnt                  = gen_cnt + 2'd1;
      end
      gen[gen_cnt].token_class = mlt_pkg::ClsEof;
      gen_cnt                  = gen_cnt + 2'd1;
      flush                    = 1'b1;
      at_line_start_nxt        = 1'b1;
      line_has_content_nxt     = 1'b0;
      in_comment_nxt           = 1'b0;
      whole_line_mode_nxt      = 1'b0;
    end else if (ch == mlt_pkg::ChNewline) begin
      if (pend_tok) begin
        gen[gen_cnt] = tok_rec;
        gen_cnt      = gen_cnt + 2'd1;
      end
      gen[gen_cnt].token_class = mlt_pkg::ClsNewline;
      gen_cnt                  = gen_cnt + 2'd1;
      flush                    = 1'b1;
      at_line_start_nxt        = 1'b1;
      line_has_content_nxt     = 1'b0;
      in_comment_nxt           = 1'b0;
      whole_line_mode_nxt      = 1'b0;
    end else begin
      at_line_start_nxt    = 1'b0;
      line_has_content_nxt = 1'b1;
      if (in_comment_r) begin
        // drop comment text
      end else if (ch == mlt_pkg::ChHash) begin
        if (pend_tok) begin
          gen[0]  = tok_rec;
          gen_cnt = 2'd1;
        end
        flush          = 1'b1;
        in_comment_nxt = 1'b1;
      end else if (at_line_start_r && ch == mlt_pkg::ChTab) begin
        gen[0].token_class  = mlt_pkg::ClsTab;
        gen_cnt             = 2'd1;
        whole_line_mode_nxt = 1'b1;
      end else if (ch == mlt_pkg::ChSpace && !whole_line_mode_r) begin
        if (pend_tok) begin
          gen[0]  = tok_rec;
          gen_cnt = 2'd1;
        end
        flush = 1'b1;
      end else begin
        // Token byte: capture the first two bytes, count with saturation
        if (cur_len_r == '0) begin
          first_byte_nxt = ch;
        end else if (cur_len_r == mlt_pkg::LenWidth'(1)) begin
          second_byte_nxt = ch;
        end
        if (cur_len_r != mlt_pkg::LenMax) begin
          cur_len_nxt = cur_len_r + mlt_pkg::LenWidth'(1);
        end
        gen[0].record_kind   = mlt_pkg::KindEcho;
        gen[0].out_character = ch;
        gen_cnt              = 2'd1;
      end
    end

    if (flush) begin
      cur_len_nxt     = '0;
      first_byte_nxt  = 8'd0;
      second_byte_nxt = 8'd0;
    end

    // Mark the final result of the item
    for (int i = 0; i < mlt_pkg::MaxResults; i++) begin
      gen[i].last_of_run = (2'(i + 1) == gen_cnt);
    end
  end

  // Queue occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_fire) begin
      cnt_nxt = gen_cnt;
    end else if (out_fire) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r              <= 2'd0;
      at_line_start_r    <= 1'b1;
      line_has_content_r <= 1'b0;
      in_comment_r       <= 1'b0;
      whole_line_mode_r  <= 1'b0;
      cur_len_r          <= '0;
      first_byte_r       <= 8'd0;
      second_byte_r      <= 8'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_fire) begin
        at_line_start_r    <= at_line_start_nxt;
        line_has_content_r <= line_has_content_nxt;
        in_comment_r       <= in_comment_nxt;
        whole_line_mode_r  <= whole_line_mode_nxt;
        cur_len_r          <= cur_len_nxt;
        first_byte_r       <= first_byte_nxt;
        second_byte_r      <= second_byte_nxt;
      end
    end
  end

  // Result payload: load on accept, advance on each taken result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < mlt_pkg::MaxResults; i++) begin
        rec_r[i] <= gen[i];
      end
    end else if (out_fire) begin
      for (int i = 0; i < mlt_pkg::MaxResults - 1; i++) begin
        rec_r[i] <= rec_r[i+1];
      end
    end
  end

  // Drive the result channel from the queue head
  assign out_chan.valid         = (cnt_r != 2'd0);
  assign out_chan.record_kind   = rec_r[0].record_kind;
  assign out_chan.out_character = rec_r[0].out_character;
  assign out_chan.token_class   = rec_r[0].token_class;
  assign out_chan.token_length  = rec_r[0].token_length;
  assign out_chan.last_of_run   = rec_r[0].last_of_run;

`ifndef NO_ASSERTIONS
  // Input is taken only when no earlier result would be overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (cnt_r == 2'd0 || (cnt_r == 2'd1 && out_fire)))
    else $error("item accepted over pending results");

  // The final queued result closes the run
  a_last_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> out_chan.last_of_run)
    else $error("last queued result lacks last_of_run");

  // An end marker yields results and returns the scan to line start
  a_eof_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_chan.end_of_input) |=>
      (out_chan.valid && at_line_start_r && cur_len_r == '0 && !in_comment_r))
    else $error("end marker did not restart the scan");

  // Echo records carry no length
  a_echo_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.record_kind == mlt_pkg::KindEcho) |->
      (out_chan.token_length == 16'd0))
    else $error("echo record with nonzero length");
`endif

endmodule
